### hw/rtl/sfr_pkg.sv
// shared types, constants and codes for the segment fault resolver
`default_nettype none

package sfr_pkg;

   // default configuration
   localparam int ENTRIES_DEF    = 64;
   localparam int PAGE_BYTES_DEF = 4096;

   // fixed field widths
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 2;
   localparam int MATCH_W  = 6;
   localparam int BYTE_W   = 44;

   // operation codes
   localparam logic OP_APPEND  = 1'b0;
   localparam logic OP_RESOLVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_APPENDED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RESOLVED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

   // one segment table entry
   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] length;
      logic [ADDR_W-1:0] file_start;
   } entry_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic scan_start;
      logic scan_step;
      logic finish_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic issue_done;
      logic rd_pending;
      logic cmp_hit;
   } status_type;

endpackage

`default_nettype wire

### hw/rtl/segment_fault_resolver.sv
// top level of the segment fault resolver: controller plus datapath
//
// Segment table with a first-match page fault lookup. An append beat
// (operation 0) stores base, length and file start in the next free slot,
// or reports table full once ENTRIES slots are used. A resolve beat
// (operation 1) scans the table from slot 0 upward and returns the first
// segment with base <= address < base + length (end taken at 33 bits),
// the page start, the file position of that page and the running fault,
// mapped-byte and fragmentation-byte counts, all saturating. Every input
// beat gives exactly one result beat. An append goes from acceptance
// straight to the finish step; a resolve first scans the table through
// the single read port of the table memory, which delivers one slot per
// cycle to the range compare, until the first hit or the last filled slot.
// A stalled earlier result holds back the finish step until it is taken.
// One item is in work at a time; the next beat is taken as soon as the
// previous result is in the output register, even while that result is
// still stalled. The table memory is not cleared at reset; only filled
// slots are ever searched. PAGE_BYTES must be a power of two.
`default_nettype none

module segment_fault_resolver #(
   parameter int ENTRIES    = sfr_pkg::ENTRIES_DEF,
   parameter int PAGE_BYTES = sfr_pkg::PAGE_BYTES_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   // input beats
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_operation,
   input  wire  [sfr_pkg::ADDR_W-1:0]   req_segment_base,
   input  wire  [sfr_pkg::ADDR_W-1:0]   req_segment_length,
   input  wire  [sfr_pkg::ADDR_W-1:0]   req_segment_file_start,
   input  wire  [sfr_pkg::ADDR_W-1:0]   req_fault_address,
   // result beats
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [sfr_pkg::STATUS_W-1:0] rsp_status,
   output logic [sfr_pkg::MATCH_W-1:0]  rsp_matched_index,
   output logic [sfr_pkg::ADDR_W-1:0]   rsp_page_start,
   output logic [sfr_pkg::ADDR_W-1:0]   rsp_file_position,
   output logic [sfr_pkg::ADDR_W-1:0]   rsp_fault_total,
   output logic [sfr_pkg::BYTE_W-1:0]   rsp_mapped_bytes,
   output logic [sfr_pkg::BYTE_W-1:0]   rsp_waste_bytes
);
   import sfr_pkg::*;

   // command and status bundles between controller and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: accept, scan, finish
   sfr_control u_control (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .status        (status)
   );

   // table memory, search pipeline, counters and result register
   sfr_datapath #(
      .ENTRIES    (ENTRIES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_operation          (req_operation),
      .req_segment_base       (req_segment_base),
      .req_segment_length     (req_segment_length),
      .req_segment_file_start (req_segment_file_start),
      .req_fault_address      (req_fault_address),
      .rsp_status             (rsp_status),
      .rsp_matched_index      (rsp_matched_index),
      .rsp_page_start         (rsp_page_start),
      .rsp_file_position      (rsp_file_position),
      .rsp_fault_total        (rsp_fault_total),
      .rsp_mapped_bytes       (rsp_mapped_bytes),
      .rsp_waste_bytes        (rsp_waste_bytes)
   );

endmodule

`default_nettype wire

### hw/rtl/sfr_datapath.sv
// segment table memory, search pipeline, counters and result register
`default_nettype none

module sfr_datapath #(
   parameter int ENTRIES    = sfr_pkg::ENTRIES_DEF,
   parameter int PAGE_BYTES = sfr_pkg::PAGE_BYTES_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire sfr_pkg::cmd_type                  cmd,
   output sfr_pkg::status_type                    status,
   input  wire                                    req_operation,
   input  wire  [sfr_pkg::ADDR_W-1:0]             req_segment_base,
   input  wire  [sfr_pkg::ADDR_W-1:0]             req_segment_length,
   input  wire  [sfr_pkg::ADDR_W-1:0]             req_segment_file_start,
   input  wire  [sfr_pkg::ADDR_W-1:0]             req_fault_address,
   output logic [sfr_pkg::STATUS_W-1:0]           rsp_status,
   output logic [sfr_pkg::MATCH_W-1:0]            rsp_matched_index,
   output logic [sfr_pkg::ADDR_W-1:0]             rsp_page_start,
   output logic [sfr_pkg::ADDR_W-1:0]             rsp_file_position,
   output logic [sfr_pkg::ADDR_W-1:0]             rsp_fault_total,
   output logic [sfr_pkg::BYTE_W-1:0]             rsp_mapped_bytes,
   output logic [sfr_pkg::BYTE_W-1:0]             rsp_waste_bytes
);
   import sfr_pkg::*;

   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PAGE_BITS = $clog2(PAGE_BYTES);

   // captured item
   logic                  op_ff;
   logic [ADDR_W-1:0]     base_ff, length_ff, fstart_ff, addr_ff;

   // segment table, no reset: only entries below the fill count are read
   entry_type             entry_mem_ff [ENTRIES];
   entry_type             rd_data_ff;
   logic [CNT_W-1:0]      count_ff;

   // search pipeline
   logic [CNT_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic                  issue;
   logic [ADDR_W:0]       range_end;
   logic                  cmp_hit;

   // first hit
   logic                  found_ff;
   logic [IDX_W-1:0]      found_idx_ff;
   entry_type             found_entry_ff;

   // counters
   logic [ADDR_W-1:0]     fault_ff;
   logic [BYTE_W-1:0]     mapped_ff, waste_ff;

   // result payload
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [MATCH_W-1:0]    rsp_index_ff;
   logic [ADDR_W-1:0]     rsp_page_ff, rsp_fpos_ff;

   // finish stage arithmetic
   logic                  table_full;
   logic                  do_append, do_resolve;
   logic [ADDR_W-1:0]     page;
   logic [ADDR_W-1:0]     fpos;
   logic [PAGE_BITS:0]    waste_step;
   logic [BYTE_W:0]       mapped_sum, waste_sum;
   logic [IDX_W+MATCH_W-1:0] found_idx_ext, append_idx_ext;

   // ---------------------------------------------------------------- capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         base_ff   <= req_segment_base;
         length_ff <= req_segment_length;
         fstart_ff <= req_segment_file_start;
         addr_ff   <= req_fault_address;
      end
   end

   // ---------------------------------------------------------------- search
   assign issue = cmd.scan_step && (rd_ptr_ff != count_ff);

   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      rd_valid_in = 1'b0;
      if (cmd.scan_start) begin
         rd_ptr_in = '0;
      end else if (issue) begin
         rd_ptr_in   = rd_ptr_ff + CNT_W'(1);
         rd_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff   <= rd_ptr_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem_ff[rd_ptr_ff[IDX_W-1:0]];
      rd_idx_ff  <= rd_ptr_ff[IDX_W-1:0];
   end

   // range end kept at 33 bits so it never wraps
   assign range_end = {1'b0, rd_data_ff.base} + {1'b0, rd_data_ff.length};
   assign cmp_hit   = rd_valid_ff && (addr_ff >= rd_data_ff.base)
                      && ({1'b0, addr_ff} < range_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         found_ff <= 1'b0;
      end else if (cmd.scan_step && cmp_hit && !found_ff) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && cmp_hit && !found_ff) begin
         found_idx_ff   <= rd_idx_ff;
         found_entry_ff <= rd_data_ff;
      end
   end

   assign status.issue_done = (rd_ptr_ff == count_ff);
   assign status.rd_pending = rd_valid_ff;
   assign status.cmp_hit    = cmp_hit;

   // ---------------------------------------------------------------- finish
   assign table_full = (count_ff == CNT_W'(ENTRIES));
   assign do_append  = cmd.finish_load && (op_ff == OP_APPEND) && !table_full;
   assign do_resolve = cmd.finish_load && (op_ff == OP_RESOLVE) && found_ff;

   assign page       = {addr_ff[ADDR_W-1:PAGE_BITS], PAGE_BITS'(0)};
   assign fpos       = found_entry_ff.file_start + (page - found_entry_ff.base);
   assign waste_step = (PAGE_BITS+1)'(PAGE_BYTES)
                       - {1'b0, found_entry_ff.length[PAGE_BITS-1:0]};
   assign mapped_sum = {1'b0, mapped_ff} + (BYTE_W+1)'(PAGE_BYTES);
   assign waste_sum  = {1'b0, waste_ff} + (BYTE_W+1)'(waste_step);

   assign found_idx_ext  = {{MATCH_W{1'b0}}, found_idx_ff};
   assign append_idx_ext = {{MATCH_W{1'b0}}, count_ff[IDX_W-1:0]};

   always_ff @(posedge clock) begin
      if (do_append) begin
         entry_mem_ff[count_ff[IDX_W-1:0]] <= '{base: base_ff, length: length_ff,
                                                file_start: fstart_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         fault_ff  <= '0;
         mapped_ff <= '0;
         waste_ff  <= '0;
      end else begin
         if (do_append) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (do_resolve) begin
            if (fault_ff != '1) begin
               fault_ff <= fault_ff + ADDR_W'(1);
            end
            mapped_ff <= mapped_sum[BYTE_W] ? '1 : mapped_sum[BYTE_W-1:0];
            waste_ff  <= waste_sum[BYTE_W]  ? '1 : waste_sum[BYTE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish_load) begin
         rsp_index_ff <= '0;
         rsp_page_ff  <= '0;
         rsp_fpos_ff  <= '0;
         if (op_ff == OP_APPEND) begin
            if (table_full) begin
               rsp_status_ff <= STATUS_FULL;
            end else begin
               rsp_status_ff <= STATUS_APPENDED;
               rsp_index_ff  <= append_idx_ext[MATCH_W-1:0];
            end
         end else if (found_ff) begin
            rsp_status_ff <= STATUS_RESOLVED;
            rsp_index_ff  <= found_idx_ext[MATCH_W-1:0];
            rsp_page_ff   <= page;
            rsp_fpos_ff   <= fpos;
         end else begin
            rsp_status_ff <= STATUS_NO_MATCH;
         end
      end
   end

   // counters only move on a finish load, which waits for the output to be free
   assign rsp_status        = rsp_status_ff;
   assign rsp_matched_index = rsp_index_ff;
   assign rsp_page_start    = rsp_page_ff;
   assign rsp_file_position = rsp_fpos_ff;
   assign rsp_fault_total   = fault_ff;
   assign rsp_mapped_bytes  = mapped_ff;
   assign rsp_waste_bytes   = waste_ff;

endmodule

`default_nettype wire

### hw/rtl/sfr_control.sv
// sequencing state machine and result valid for the segment fault resolver
`default_nettype none

module sfr_control (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire                    req_operation,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output sfr_pkg::cmd_type       cmd,
   input  wire sfr_pkg::status_type status
);
   import sfr_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_operation == OP_APPEND) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.cmp_hit) begin
               state_in = S_FINISH;
            end else if (status.issue_done && !status.rd_pending) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### hw/rtl/sfr_checker.sv
// port level checks for the segment fault resolver, bound to the top level
`default_nettype none

module sfr_checker #(
   parameter int PAGE_BYTES = sfr_pkg::PAGE_BYTES_DEF
) (
   input wire                          clock,
   input wire                          reset,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire [sfr_pkg::STATUS_W-1:0]  rsp_status,
   input wire [sfr_pkg::MATCH_W-1:0]   rsp_matched_index,
   input wire [sfr_pkg::ADDR_W-1:0]    rsp_page_start,
   input wire [sfr_pkg::ADDR_W-1:0]    rsp_file_position,
   input wire [sfr_pkg::ADDR_W-1:0]    rsp_fault_total
);
   import sfr_pkg::*;

   localparam int PAGE_BITS = $clog2(PAGE_BYTES);

   // settle shift register, filled after reset, gates the history checks
   logic [1:0] settled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         settled_ff <= '0;
      end else begin
         settled_ff <= {settled_ff[0], 1'b1};
      end
   end

   // a stalled result beat stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // fault count never goes backward outside reset
   assert property (@(posedge clock) disable iff (reset)
      settled_ff[1] |-> rsp_fault_total >= $past(rsp_fault_total))
      else $error("fault count decreased");

   // non-resolve beats carry no page and no file position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_RESOLVED)
      |-> (rsp_page_start == '0) && (rsp_file_position == '0))
      else $error("page fields set on a non-resolve beat");

   // failed beats carry index zero, resolved pages are aligned
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == STATUS_NO_MATCH) || (rsp_status == STATUS_FULL))
      |-> (rsp_matched_index == '0))
      else $error("index set on a failed beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_RESOLVED)
      |-> (rsp_page_start[PAGE_BITS-1:0] == '0))
      else $error("page start not aligned");

endmodule

bind segment_fault_resolver sfr_checker #(
   .PAGE_BYTES (PAGE_BYTES)
) u_sfr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_matched_index (rsp_matched_index),
   .rsp_page_start    (rsp_page_start),
   .rsp_file_position (rsp_file_position),
   .rsp_fault_total   (rsp_fault_total)
);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the segment fault resolver: directed and random beats
module tb_top;
   import sfr_pkg::*;

   localparam int ENTRIES    = ENTRIES_DEF;
   localparam int PAGE_BYTES = PAGE_BYTES_DEF;
   localparam logic [BYTE_W-1:0] BYTE_TOP = '1;

   // one predicted result beat
   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [MATCH_W-1:0]  index;
      logic [ADDR_W-1:0]   page;
      logic [ADDR_W-1:0]   file_pos;
      logic [ADDR_W-1:0]   faults;
      logic [BYTE_W-1:0]   mapped;
      logic [BYTE_W-1:0]   waste;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid              = 1'b0;
   logic              req_stall;
   logic              req_operation          = OP_APPEND;
   logic [ADDR_W-1:0] req_segment_base       = '0;
   logic [ADDR_W-1:0] req_segment_length     = '0;
   logic [ADDR_W-1:0] req_segment_file_start = '0;
   logic [ADDR_W-1:0] req_fault_address      = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [MATCH_W-1:0]  rsp_matched_index;
   logic [ADDR_W-1:0]   rsp_page_start;
   logic [ADDR_W-1:0]   rsp_file_position;
   logic [ADDR_W-1:0]   rsp_fault_total;
   logic [BYTE_W-1:0]   rsp_mapped_bytes;
   logic [BYTE_W-1:0]   rsp_waste_bytes;

   // shadow copy of the segment table and the running counters
   logic [ADDR_W-1:0] seg_base [ENTRIES];
   logic [ADDR_W-1:0] seg_len  [ENTRIES];
   logic [ADDR_W-1:0] seg_file [ENTRIES];
   int                seg_count  = 0;
   logic [ADDR_W-1:0] fault_cnt  = '0;
   logic [BYTE_W-1:0] mapped_cnt = '0;
   logic [BYTE_W-1:0] waste_cnt  = '0;

   // results still owed by the block, oldest first
   lookup_result_type pending_results [$];
   lookup_result_type want_result;

   int fail_count   = 0;
   int result_beats = 0;
   int hold_left    = 0;
   bit req_burst    = 1'b0;
   bit rsp_burst    = 1'b0;

   segment_fault_resolver #(
      .ENTRIES   (ENTRIES),
      .PAGE_BYTES(PAGE_BYTES)
   ) uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_segment_base      (req_segment_base),
      .req_segment_length    (req_segment_length),
      .req_segment_file_start(req_segment_file_start),
      .req_fault_address     (req_fault_address),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_matched_index     (rsp_matched_index),
      .rsp_page_start        (rsp_page_start),
      .rsp_file_position     (rsp_file_position),
      .rsp_fault_total       (rsp_fault_total),
      .rsp_mapped_bytes      (rsp_mapped_bytes),
      .rsp_waste_bytes       (rsp_waste_bytes)
   );

   initial forever #6 clock = ~clock;

   // hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // predicted outcome of one accepted beat; updates the shadow state
   function automatic lookup_result_type predict_lookup(
      input logic              op,
      input logic [ADDR_W-1:0] base,
      input logic [ADDR_W-1:0] len,
      input logic [ADDR_W-1:0] fstart,
      input logic [ADDR_W-1:0] addr
   );
      lookup_result_type r;
      logic [ADDR_W:0] seg_end;
      logic [BYTE_W:0] sum;
      bit found;
      r.status   = STATUS_NO_MATCH;
      r.index    = '0;
      r.page     = '0;
      r.file_pos = '0;
      found      = 1'b0;
      if (op == OP_APPEND) begin
         if (seg_count >= ENTRIES) begin
            r.status = STATUS_FULL;
         end else begin
            seg_base[seg_count] = base;
            seg_len[seg_count]  = len;
            seg_file[seg_count] = fstart;
            r.status = STATUS_APPENDED;
            r.index  = MATCH_W'(seg_count);
            seg_count++;
         end
      end else begin
         // first match from slot 0 upward, range end kept at 33 bits
         for (int k = 0; k < seg_count && !found; k++) begin
            seg_end = {1'b0, seg_base[k]} + {1'b0, seg_len[k]};
            if (addr >= seg_base[k] && {1'b0, addr} < seg_end) begin
               found      = 1'b1;
               r.status   = STATUS_RESOLVED;
               r.index    = MATCH_W'(k);
               r.page     = addr & ~ADDR_W'(PAGE_BYTES - 1);
               // page below an unaligned base wraps here
               r.file_pos = seg_file[k] + (r.page - seg_base[k]);
               if (fault_cnt != '1) fault_cnt++;
               sum        = {1'b0, mapped_cnt} + PAGE_BYTES;
               mapped_cnt = (sum > BYTE_TOP) ? BYTE_TOP : sum[BYTE_W-1:0];
               // whole-page lengths add a full page of waste
               sum        = {1'b0, waste_cnt} + (PAGE_BYTES - seg_len[k] % PAGE_BYTES);
               waste_cnt  = (sum > BYTE_TOP) ? BYTE_TOP : sum[BYTE_W-1:0];
            end
         end
      end
      r.faults = fault_cnt;
      r.mapped = mapped_cnt;
      r.waste  = waste_cnt;
      return r;
   endfunction

   // address inside a random filled segment, often at its first or last byte
   function automatic logic [ADDR_W-1:0] address_in_segment();
      int k;
      longint unsigned span;
      longint unsigned off;
      k    = $urandom_range(0, seg_count - 1);
      span = 64'h1_0000_0000 - seg_base[k];
      if (seg_len[k] < span) span = seg_len[k];
      if (span == 0) return $urandom;
      case ($urandom_range(0, 3))
         0: begin
            off = 0;
         end
         1: begin
            off = span - 1;
         end
         default: begin
            off = {$urandom} % span;
         end
      endcase
      return seg_base[k] + ADDR_W'(off);
   endfunction

   // present one beat after a random gap and hold it until accepted
   task automatic send_item(
      input logic              op,
      input logic [ADDR_W-1:0] base,
      input logic [ADDR_W-1:0] len,
      input logic [ADDR_W-1:0] fstart,
      input logic [ADDR_W-1:0] addr
   );
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_operation          <= op;
      req_segment_base       <= base;
      req_segment_length     <= len;
      req_segment_file_start <= fstart;
      req_fault_address      <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(predict_lookup(op, base, len, fstart, addr));
   endtask

   // mostly short segments so that deep slots still get hit
   task automatic append_random_segment();
      logic [ADDR_W-1:0] len;
      case ($urandom_range(0, 31))
         0: begin
            len = '0;
         end
         1: begin
            len = $urandom;
         end
         2, 3, 4: begin
            len = ADDR_W'($urandom_range(1, 16)) * PAGE_BYTES;
         end
         default: begin
            len = $urandom_range(1, 16 * PAGE_BYTES);
         end
      endcase
      send_item(OP_APPEND, $urandom, len, $urandom, $urandom);
   endtask

   task automatic check_field(
      input string             name,
      input logic [BYTE_W-1:0] want,
      input logic [BYTE_W-1:0] got
   );
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // segments for the special cases; unused fields carry random bits
   task automatic test_directed_appends();
      // whole pages, so every hit adds a full page of waste
      send_item(OP_APPEND, 32'h0000_1000, 32'h0000_3000, 32'h0000_0100, $urandom);
      // overlaps the one above, file start near the top so the position wraps
      send_item(OP_APPEND, 32'h0000_2800, 32'h0000_2000, 32'hFFFF_F000, $urandom);
      // unaligned base, page starts below it
      send_item(OP_APPEND, 32'h8000_0123, 32'h0000_1234, 32'h0000_0010, $urandom);
      // end runs past the top of the address space
      send_item(OP_APPEND, 32'hFFFF_F800, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom);
      // zero length, never hit
      send_item(OP_APPEND, 32'h4000_0000, 32'h0000_0000, 32'h0000_0000, $urandom);
      // single byte at address zero
      send_item(OP_APPEND, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, $urandom);
      // top byte, always shadowed by the wide segment
      send_item(OP_APPEND, 32'hFFFF_FFFF, 32'h0000_0010, 32'h1234_5000, $urandom);
   endtask

   task automatic test_directed_resolves();
      logic [ADDR_W-1:0] probe [13];
      probe = '{32'h0000_0000, 32'h0000_0001, 32'h0000_1000, 32'h0000_3FFF,
                32'h0000_4000, 32'h0000_2900, 32'h0000_4800, 32'h8000_0150,
                32'h8000_1356, 32'h8000_1357, 32'h4000_0000, 32'hFFFF_FFFF,
                32'hFFFF_F800};
      foreach (probe[i]) send_item(OP_RESOLVE, $urandom, $urandom, $urandom, probe[i]);
      send_item(OP_RESOLVE, $urandom, $urandom, $urandom, 32'h7FFF_FFFF);
   endtask

   // resolves dominate; appends fill the table and later get refused
   task automatic test_random_traffic(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 32 == 0) req_burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0)
            append_random_segment();
         else if (seg_count > 0 && $urandom_range(0, 3) != 0)
            send_item(OP_RESOLVE, $urandom, $urandom, $urandom, address_in_segment());
         else
            send_item(OP_RESOLVE, $urandom, $urandom, $urandom, $urandom);
      end
      req_burst = 1'b0;
   endtask

   // top up the table, then appends must be refused while lookups still work
   task automatic test_table_full();
      while (seg_count < ENTRIES) append_random_segment();
      repeat (3) begin
         send_item(OP_APPEND, $urandom, $urandom, $urandom, $urandom);
         send_item(OP_RESOLVE, $urandom, $urandom, $urandom, address_in_segment());
      end
      send_item(OP_APPEND, '1, '1, '1, '1);
      send_item(OP_RESOLVE, '0, '0, '0, $urandom);
   endtask

   // result side: compare each beat, then draw a stall for the next one
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result beat with no lookup pending");
               fail_count++;
            end else begin
               want_result = pending_results.pop_front();
               check_field("status", want_result.status, rsp_status);
               check_field("matched_index", want_result.index, rsp_matched_index);
               check_field("page_start", want_result.page, rsp_page_start);
               check_field("file_position", want_result.file_pos, rsp_file_position);
               check_field("fault_total", want_result.faults, rsp_fault_total);
               check_field("mapped_bytes", want_result.mapped, rsp_mapped_bytes);
               check_field("waste_bytes", want_result.waste, rsp_waste_bytes);
            end
            result_beats++;
            // stretches of back-to-back acceptance now and then
            if (result_beats % 32 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
            hold_left = rsp_burst ? 0 : $urandom_range(0, 16);
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left != 0);
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_appends();
      test_directed_resolves();
      test_random_traffic(1000);
      test_table_full();
      req_valid <= 1'b0;
      // drain, then allow for one full scan before judging
      while (pending_results.size() != 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_datapath.sv
hw/rtl/sfr_control.sv
hw/rtl/segment_fault_resolver.sv
hw/rtl/sfr_checker.sv
dv/tb_top.sv
